// ===== src/assert_macros.svh =====
// Assertion macros for the odometry RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("odometry check failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("odometry forbidden condition seen");
`else
`define ASSERT_AT(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== src/ddo_pkg.sv =====
// Package of the odometry unit: widths, constants, state codes, request structs
// and the quarter-wave sine table function. No dependencies.
`default_nettype none
package ddo_pkg;
	localparam int ANG_W     = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int HEAD_W    = 19;
	localparam int POS_W     = 40;
	localparam int DIST_W    = 40;
	localparam int A_W       = 41;
	localparam int MB_W      = 18;
	localparam int PROD_W    = 59;
	localparam int MCNT_W    = 5;
	localparam int SIN_W     = 18;

	localparam int PI_Q     = 205887;
	localparam int TWO_PI_Q = 411774;

	localparam int DEF_ANGLE_FRAC_BITS    = 16;
	localparam int DEF_SINE_TABLE_ENTRIES = 1024;

	localparam logic [CFG_W-1:0] RST_WHEEL_RADIUS = 16'd832;
	localparam logic [CFG_W-1:0] RST_INV_BASE     = 16'd2731;

	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_BASE     = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE, S_ML, S_MR, S_MT, S_HEAD, S_DIV0, S_DIV,
		S_RS, S_RC, S_MXS, S_MX, S_MY, S_DONE
	} state_t;

	typedef struct packed {
		logic                  start;
		logic signed [A_W-1:0] a;
		logic signed [MB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic [HEAD_W-1:0] u;
	} div_req_t;

	// Sine of a quarter-wave point, Q1.16, from a Q30 Taylor series.
	function automatic logic [SIN_W-1:0] qsin(input int unsigned idx, input int unsigned logn);
		longint unsigned half_pi, one, rem, x, x2, t, s;
		half_pi = 64'd1686629713;
		one = 64'd1073741824;
		rem = 64'(idx) * 64'd4;
		x = (half_pi * rem) >> logn;
		x2 = (x * x) >> 30;
		t = one - x2 / 64'd110;
		t = one - ((x2 * t) >> 30) / 64'd72;
		t = one - ((x2 * t) >> 30) / 64'd42;
		t = one - ((x2 * t) >> 30) / 64'd20;
		t = one - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		s = (s + 64'd8192) >> 14;
		if (s > 64'd65536) begin
			s = 64'd65536;
		end
		return s[SIN_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== src/diff_drive_odometry_unit.sv =====
// Differential-drive odometry top level: sequencer, pose state, config.
// Depends on ddo_pkg, ddo_ser_mul, ddo_ser_div, ddo_trig_rom, assert_macros.svh.
// Each item takes five passes through the shared multiplier (left, right, turn, x, y),
// a divide into a table index and a sine and cosine read. One item at a time; the first
// item after reset only primes the previous wheel angles and gives no output.
// Reset (async, active low) clears the pose, the primed flag and the output valid, and loads the config defaults.
`default_nettype none
`include "assert_macros.svh"
module diff_drive_odometry_unit #(
	parameter int ANGLE_FRAC_BITS    = ddo_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int SINE_TABLE_ENTRIES = ddo_pkg::DEF_SINE_TABLE_ENTRIES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ddo_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ddo_pkg::ANG_W-1:0]     left_wheel_angle,
	input  logic signed [ddo_pkg::ANG_W-1:0]     right_wheel_angle,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ddo_pkg::POS_W-1:0]     pos_x,
	output logic signed [ddo_pkg::POS_W-1:0]     pos_y,
	output logic signed [ddo_pkg::HEAD_W-1:0]    heading
);
	import ddo_pkg::*;

	localparam int LOGN = $clog2(SINE_TABLE_ENTRIES);
	localparam int QN   = SINE_TABLE_ENTRIES / 4;
	localparam int DSH  = ANGLE_FRAC_BITS - 8;

	state_t state_q, state_d;

	logic [CFG_W-1:0]         wr_q;
	logic [CFG_W-1:0]         iwb_q;
	logic signed [ANG_W-1:0]  prev_l_q;
	logic signed [ANG_W-1:0]  prev_r_q;
	logic                     primed_q;
	logic signed [ANG_W-1:0]  der_q;
	logic signed [DIST_W-1:0] dl_q;
	logic signed [A_W-1:0]    sum_q;
	logic signed [HEAD_W-1:0] turn_q;
	logic signed [HEAD_W-1:0] head_q;
	logic [LOGN-1:0]          k_q;
	logic signed [SIN_W-1:0]  sin_q;
	logic signed [POS_W-1:0]  x_q;
	logic signed [POS_W-1:0]  y_q;
	logic                     out_valid_q;
	logic signed [POS_W-1:0]  pos_x_q;
	logic signed [POS_W-1:0]  pos_y_q;
	logic signed [HEAD_W-1:0] heading_q;

	mul_req_t                 mul_req;
	logic                     mul_done;
	logic signed [PROD_W-1:0] mul_prod;
	div_req_t                 div_req;
	logic                     div_done;
	logic [LOGN-1:0]          div_k;
	logic [LOGN-1:0]          rom_k;
	logic signed [SIN_W-1:0]  rom_val;

	logic                     in_acc;
	logic                     out_go;
	logic                     mul_st;
	logic signed [ANG_W-1:0]  del;
	logic signed [DIST_W-1:0] wheel_dist;
	logic signed [PROD_W-17:0] turn_raw;
	logic signed [HEAD_W-1:0] turn_sat;
	logic signed [20:0]       h_sum;
	logic signed [20:0]       h_wrap;
	logic signed [20:0]       u_full;

	ddo_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ddo_ser_div #(.LOGN(LOGN)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.k      (div_k)
	);

	ddo_trig_rom #(.LOGN(LOGN)) u_rom (
		.clk (clk),
		.k   (rom_k),
		.val (rom_val)
	);

	assign cfg_ready  = 1'b1;
	assign in_acc     = in_valid && in_ready;
	assign out_go     = !out_valid_q || out_ready;
	assign mul_st     = state_q inside {S_ML, S_MR, S_MT, S_MX, S_MY};
	assign del        = left_wheel_angle - prev_l_q;
	assign wheel_dist = $signed(mul_prod[DSH +: DIST_W]);
	assign turn_raw   = $signed(mul_prod[PROD_W-1:16]);
	assign turn_sat   = (turn_raw > (PROD_W-16)'(PI_Q)) ? HEAD_W'(PI_Q) :
		(turn_raw < -(PROD_W-16)'(PI_Q)) ? -HEAD_W'(PI_Q) : HEAD_W'(turn_raw);
	assign h_sum      = 21'(head_q) + 21'(turn_q);
	assign h_wrap     = (h_sum > 21'(PI_Q)) ? h_sum - 21'(TWO_PI_Q) :
		(h_sum <= -21'(PI_Q)) ? h_sum + 21'(TWO_PI_Q) : h_sum;
	assign u_full     = (head_q < 0) ? 21'(head_q) + 21'(TWO_PI_Q) : 21'(head_q);
	assign rom_k      = (state_q == S_RS) ? k_q : k_q + LOGN'(QN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		mul_req.start = 1'b0;
		mul_req.a     = sum_q;
		mul_req.b     = sin_q;
		div_req.start = 1'b0;
		div_req.u     = u_full[HEAD_W-1:0];
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && primed_q) begin
					mul_req.start = 1'b1;
					mul_req.a     = A_W'(del);
					mul_req.b     = $signed({2'b00, wr_q});
					state_d       = S_ML;
				end
			end
			S_ML: begin
				if (mul_done) begin
					mul_req.start = 1'b1;
					mul_req.a     = A_W'(der_q);
					mul_req.b     = $signed({2'b00, wr_q});
					state_d       = S_MR;
				end
			end
			S_MR: begin
				if (mul_done) begin
					mul_req.start = 1'b1;
					mul_req.a     = A_W'(wheel_dist) - A_W'(dl_q);
					mul_req.b     = $signed({2'b00, iwb_q});
					state_d       = S_MT;
				end
			end
			S_MT: begin
				if (mul_done) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: state_d = S_DIV0;
			S_DIV0: begin
				div_req.start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_RS;
				end
			end
			S_RS: state_d = S_RC;
			S_RC: state_d = S_MXS;
			S_MXS: begin
				mul_req.start = 1'b1;
				mul_req.b     = rom_val;
				state_d       = S_MX;
			end
			S_MX: begin
				if (mul_done) begin
					mul_req.start = 1'b1;
					state_d       = S_MY;
				end
			end
			S_MY: begin
				if (mul_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= RST_WHEEL_RADIUS;
			iwb_q       <= RST_INV_BASE;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			primed_q    <= 1'b0;
			head_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WHEEL_RADIUS: wr_q  <= cfg_data;
					REG_INV_BASE:     iwb_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				prev_l_q <= left_wheel_angle;
				prev_r_q <= right_wheel_angle;
				primed_q <= 1'b1;
			end
			if (state_q == S_HEAD) begin
				head_q <= HEAD_W'(h_wrap);
			end
			if (state_q == S_MX && mul_done) begin
				x_q <= x_q + $signed(mul_prod[17 +: POS_W]);
			end
			if (state_q == S_MY && mul_done) begin
				y_q <= y_q + $signed(mul_prod[17 +: POS_W]);
			end
			if (state_q == S_DONE && out_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			der_q <= right_wheel_angle - prev_r_q;
		end
		if (state_q == S_ML && mul_done) begin
			dl_q <= wheel_dist;
		end
		if (state_q == S_MR && mul_done) begin
			sum_q <= A_W'(wheel_dist) + A_W'(dl_q);
		end
		if (state_q == S_MT && mul_done) begin
			turn_q <= turn_sat;
		end
		if (state_q == S_DIV && div_done) begin
			k_q <= div_k;
		end
		if (state_q == S_RC) begin
			sin_q <= rom_val;
		end
		if (state_q == S_DONE && out_go) begin
			pos_x_q   <= x_q;
			pos_y_q   <= y_q;
			heading_q <= head_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = heading_q;

	`ASSERT_NEVER(a_mul_done_state, clk, arst_n, mul_done && !mul_st)
	`ASSERT_NEVER(a_div_done_state, clk, arst_n, div_done && state_q != S_DIV)
	`ASSERT_AT(a_prime_only, clk, arst_n, (in_acc && !primed_q) |=> (primed_q && state_q == S_IDLE))
	`ASSERT_AT(a_head_range, clk, arst_n, (head_q <= HEAD_W'(PI_Q)) && (head_q > -HEAD_W'(PI_Q)))
endmodule
`default_nettype wire

// ===== src/ddo_ser_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on ddo_pkg.
`default_nettype none
module ddo_ser_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ddo_pkg::mul_req_t                 req,
	output logic                              done,
	output logic signed [ddo_pkg::PROD_W-1:0] prod
);
	import ddo_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [MCNT_W-1:0]        cnt_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] a_q;
	logic [MB_W-1:0]          b_q;
	logic                     last;

	assign last = (cnt_q == MCNT_W'(MB_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			a_q   <= PROD_W'(req.a);
			b_q   <= req.b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= last ? acc_q - a_q : acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

// ===== src/ddo_ser_div.sv =====
// Restoring divider that turns a heading in [0, 2pi) into a table index,
// one quotient bit per cycle. Depends on ddo_pkg.
`default_nettype none
module ddo_ser_div #(
	parameter int LOGN = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ddo_pkg::div_req_t req,
	output logic              done,
	output logic [LOGN-1:0]   k
);
	import ddo_pkg::*;

	localparam int NUMW = HEAD_W + LOGN;
	localparam int QB   = LOGN + 1;
	localparam int CW   = $clog2(QB + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [NUMW-1:0] rem_q;
	logic [NUMW-1:0] dvs_q;
	logic [QB-1:0]   q_q;
	logic            fits;

	assign fits = (rem_q >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= (NUMW'(req.u) << LOGN) + NUMW'(PI_Q);
			dvs_q <= NUMW'(TWO_PI_Q) << LOGN;
			q_q   <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dvs_q;
			end
			q_q   <= {q_q[QB-2:0], fits};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign done = done_q;
	assign k    = q_q[LOGN-1:0];
endmodule
`default_nettype wire

// ===== src/ddo_trig_rom.sv =====
// Quarter-wave sine table with registered read; folds a full-turn index
// into the table and applies the sign. Depends on ddo_pkg.
`default_nettype none
module ddo_trig_rom #(
	parameter int LOGN = 10
) (
	input  logic                             clk,
	input  logic [LOGN-1:0]                  k,
	output logic signed [ddo_pkg::SIN_W-1:0] val
);
	import ddo_pkg::*;

	localparam int QN = 1 << (LOGN - 2);
	localparam int IW = LOGN - 1;

	logic [SIN_W-1:0]        tab [QN+1];
	logic [IW-1:0]           idx;
	logic signed [SIN_W:0]   mag;
	logic signed [SIN_W-1:0] val_q;

	for (genvar g = 0; g <= QN; g++) begin : g_tab
		assign tab[g] = qsin(g, LOGN);
	end

	assign idx = k[LOGN-2] ? IW'(QN) - IW'(k[LOGN-3:0]) : IW'(k[LOGN-3:0]);
	assign mag = $signed({1'b0, tab[idx]});

	always_ff @(posedge clk) begin
		val_q <= SIN_W'(k[LOGN-1] ? -mag : mag);
	end

	assign val = val_q;
endmodule
`default_nettype wire
